// File: hdl/fnv_linear_probe_key_table_macros.svh
// assertion macros shared by the key table
`ifndef FNV_LINEAR_PROBE_KEY_TABLE_MACROS_SVH
`define FNV_LINEAR_PROBE_KEY_TABLE_MACROS_SVH

// property must hold on every rising clock edge outside reset
`define FLP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// implication checked in the cycle after the condition
`define FLP_ASSERT_NEXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) else $error(msg);

`endif

// File: hdl/flpkt_pkg.sv
`timescale 1ns / 1ps
package flpkt_pkg;
  localparam int LOG_SLOTS_DEF = 10;
  localparam int MAX_KEY_LEN_DEF = 32;
  localparam int VALUE_WIDTH_DEF = 40;
  localparam int OUT_W = 40;
  localparam logic [63:0] FNV_BASIS = 64'hCBF29CE484222325;
  localparam logic [63:0] FNV_PRIME = 64'h00000100000001B3;
  localparam logic [3:0] INDEX_BITS_RST = 4'd10;

  typedef enum logic [1:0] {
    ST_OK = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL = 2'd2,
    ST_TOO_LONG = 2'd3
  } status_t;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_LOOKUP = 1'b1;

  typedef enum logic [3:0] {
    S_COLLECT,
    S_MUL,
    S_START,
    S_RD,
    S_EVAL,
    S_CMP_RD,
    S_CMP_EVAL,
    S_WR_KEY,
    S_CLEAR,
    S_OUT
  } state_t;
endpackage

// File: hdl/fnv_linear_probe_key_table.sv
`timescale 1ns / 1ps
// FNV-1a keyed hash table with linear probing. Key bytes come in one per item;
// each byte is taken in S_COLLECT, then S_MUL does the 64-bit multiply by
// the FNV prime, done as a small constant product plus a shift. After the
// final byte, S_START sets up the probe walk through one slot memory with a
// registered read: each probed slot passes S_RD and S_EVAL, on a lookup each
// key byte compared on a tag and length match passes S_CMP_RD and S_CMP_EVAL,
// and on an insert each key byte written passes S_WR_KEY and, but for the
// final byte, S_CLEAR. A key that is too long skips the walk. The result is
// then loaded into an output register; S_OUT waits while the previous result
// is still held. After reset a clearing pass clears the valid marks of every
// slot before the first item is taken.
`include "fnv_linear_probe_key_table_macros.svh"
module fnv_linear_probe_key_table #(
  parameter int LOG_SLOTS = flpkt_pkg::LOG_SLOTS_DEF,
  parameter int MAX_KEY_LEN = flpkt_pkg::MAX_KEY_LEN_DEF,
  parameter int VALUE_WIDTH = flpkt_pkg::VALUE_WIDTH_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [3:0]   cfg_wdata,
  input  logic         s_tvalid,
  output logic         s_tready,
  // key_byte[7:0], blob_size[47:8], blob_offset[87:48]
  input  logic [87:0]  s_tdata,
  input  logic         s_tlast,
  // cmd
  input  logic         s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // status[1:0], found_size[41:2], found_offset[81:42]
  output logic [87:0]  m_tdata
);
  localparam int NSLOTS = 1 << LOG_SLOTS;
  localparam int KW = $clog2(MAX_KEY_LEN);
  localparam int LW = $clog2(MAX_KEY_LEN + 1);
  localparam int SLOT_W = 1 + LW + 32 + 2 * VALUE_WIDTH;
  localparam int OW = flpkt_pkg::OUT_W;

  flpkt_pkg::state_t state, state_next;

  logic [3:0]             index_bits;
  logic [63:0]            hash;
  logic [31:0]            mul_lo;
  logic [31:0]            mul_mid;
  logic [7:0]             kb_hold;
  logic [LW-1:0]          byte_count;
  logic                   overflow;
  logic                   cmd;
  logic                   cmd_last;
  logic [VALUE_WIDTH-1:0] size_r, offset_r;
  logic [LOG_SLOTS-1:0]   slot, mask;
  logic [LOG_SLOTS:0]     probes;
  logic [KW-1:0]          kidx;
  logic                   clearing;
  logic [LOG_SLOTS:0]     clr_cnt;
  logic [1:0]             status;
  logic [OW-1:0]          fsz, foff;

  // effective index width clamped to the built range
  logic [3:0] eff_bits;
  always_comb begin
    eff_bits = index_bits;
    if (eff_bits == 4'd0) eff_bits = 4'd1;
    if (32'(eff_bits) > LOG_SLOTS) eff_bits = 4'(LOG_SLOTS);
  end
  logic [LOG_SLOTS:0] span;
  assign span = (LOG_SLOTS + 1)'(1) << eff_bits;
  always_comb mask = span[LOG_SLOTS-1:0] - LOG_SLOTS'(1);

  // slot memory: valid, length, tag, size, offset
  logic                 sm_we;
  logic [LOG_SLOTS-1:0] sm_waddr;
  logic [SLOT_W-1:0]    sm_wdata, sm_rdata;
  flpkt_ram #(.WIDTH(SLOT_W), .DEPTH(NSLOTS)) u_slot_ram (
    .clk(clk), .we(sm_we), .waddr(sm_waddr), .wdata(sm_wdata),
    .raddr(slot), .rdata(sm_rdata)
  );
  logic                   rd_valid;
  logic [LW-1:0]          rd_len;
  logic [31:0]            rd_tag;
  logic [VALUE_WIDTH-1:0] rd_size, rd_off;
  assign {rd_valid, rd_len, rd_tag, rd_size, rd_off} = sm_rdata;

  // incoming key buffer
  logic          ib_we;
  logic [KW-1:0] ib_waddr;
  logic [7:0]    ib_rdata;
  flpkt_ram #(.WIDTH(8), .DEPTH(MAX_KEY_LEN)) u_in_ram (
    .clk(clk), .we(ib_we), .waddr(ib_waddr), .wdata(s_tdata[7:0]),
    .raddr(kidx), .rdata(ib_rdata)
  );

  // stored key bytes per slot
  logic                    kv_we;
  logic [LOG_SLOTS+KW-1:0] kv_addr;
  logic [7:0]              kv_rdata;
  flpkt_ram #(.WIDTH(8), .DEPTH(NSLOTS << KW)) u_key_ram (
    .clk(clk), .we(kv_we), .waddr(kv_addr), .wdata(ib_rdata),
    .raddr(kv_addr), .rdata(kv_rdata)
  );

  logic accept;
  assign s_tready = (state == flpkt_pkg::S_COLLECT) && !clearing;
  assign accept = s_tvalid && s_tready;
  assign ib_we = accept && (32'(byte_count) < MAX_KEY_LEN);
  assign ib_waddr = byte_count[KW-1:0];
  assign kv_addr = {slot, kidx};
  assign kv_we = (state == flpkt_pkg::S_WR_KEY);

  logic [63:0] xored;
  assign xored = {hash[63:8], hash[7:0] ^ kb_hold};

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      flpkt_pkg::S_COLLECT:  if (accept) state_next = flpkt_pkg::S_MUL;
      flpkt_pkg::S_MUL:      state_next = cmd_last ? flpkt_pkg::S_START
                                                   : flpkt_pkg::S_COLLECT;
      flpkt_pkg::S_START:    state_next = overflow ? flpkt_pkg::S_OUT : flpkt_pkg::S_RD;
      flpkt_pkg::S_RD:       state_next = flpkt_pkg::S_EVAL;
      flpkt_pkg::S_EVAL: begin
        if (cmd == flpkt_pkg::CMD_INSERT) begin
          if (!rd_valid) state_next = (byte_count == '0) ? flpkt_pkg::S_OUT
                                                         : flpkt_pkg::S_WR_KEY;
          else if (probes == span - (LOG_SLOTS + 1)'(1)) state_next = flpkt_pkg::S_OUT;
          else state_next = flpkt_pkg::S_RD;
        end else begin
          if (!rd_valid) state_next = flpkt_pkg::S_OUT;
          else if (rd_tag == hash[31:0] && rd_len == byte_count)
            state_next = flpkt_pkg::S_CMP_RD;
          else if (probes == span - (LOG_SLOTS + 1)'(1)) state_next = flpkt_pkg::S_OUT;
          else state_next = flpkt_pkg::S_RD;
        end
      end
      flpkt_pkg::S_CMP_RD:   state_next = flpkt_pkg::S_CMP_EVAL;
      flpkt_pkg::S_CMP_EVAL: begin
        if (kv_rdata != ib_rdata) begin
          state_next = (probes == span - (LOG_SLOTS + 1)'(1)) ? flpkt_pkg::S_OUT
                                                              : flpkt_pkg::S_RD;
        end else if (32'(kidx) + 1 == 32'(byte_count)) begin
          state_next = flpkt_pkg::S_OUT;
        end else begin
          state_next = flpkt_pkg::S_CMP_RD;
        end
      end
      flpkt_pkg::S_WR_KEY:   state_next = (32'(kidx) + 1 == 32'(byte_count))
                                          ? flpkt_pkg::S_OUT : flpkt_pkg::S_CLEAR;
      flpkt_pkg::S_CLEAR:    state_next = flpkt_pkg::S_WR_KEY;
      flpkt_pkg::S_OUT:      if (!m_tvalid || m_tready) state_next = flpkt_pkg::S_COLLECT;
      default:               state_next = flpkt_pkg::S_COLLECT;
    endcase
  end

  // slot memory write: clearing pass or insert
  always_comb begin
    sm_we = 1'b0;
    sm_waddr = slot;
    sm_wdata = {1'b1, byte_count, hash[31:0], size_r, offset_r};
    if (clearing) begin
      sm_we = 1'b1;
      sm_waddr = clr_cnt[LOG_SLOTS-1:0];
      sm_wdata = '0;
    end else if (state == flpkt_pkg::S_EVAL && cmd == flpkt_pkg::CMD_INSERT && !rd_valid) begin
      sm_we = 1'b1;
    end
  end

  logic [LOG_SLOTS-1:0] slot_inc;
  assign slot_inc = (slot + LOG_SLOTS'(1)) & mask;

  // control and datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= flpkt_pkg::S_COLLECT;
      index_bits <= flpkt_pkg::INDEX_BITS_RST;
      hash <= flpkt_pkg::FNV_BASIS;
      byte_count <= '0;
      overflow <= 1'b0;
      clearing <= 1'b1;
      clr_cnt <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) index_bits <= cfg_wdata;
      if (clearing) begin
        clr_cnt <= clr_cnt + (LOG_SLOTS + 1)'(1);
        if (clr_cnt == (LOG_SLOTS + 1)'(NSLOTS - 1)) clearing <= 1'b0;
      end
      if (accept) begin
        if (32'(byte_count) < MAX_KEY_LEN) byte_count <= byte_count + LW'(1);
        else overflow <= 1'b1;
      end
      if (state == flpkt_pkg::S_MUL) begin
        // x * prime as x * 0x1B3 plus x shifted up by 40
        hash <= {mul_mid, mul_lo};
      end
      if (state == flpkt_pkg::S_OUT && state_next == flpkt_pkg::S_COLLECT) begin
        m_tvalid <= 1'b1;
        hash <= flpkt_pkg::FNV_BASIS;
        byte_count <= '0;
        overflow <= 1'b0;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // hash multiply split: prime = 2^40 + 0x1B3
  logic [63:0] prod_lo;
  always_comb begin
    prod_lo = xored * 64'h1B3;
    mul_lo = prod_lo[31:0];
    mul_mid = prod_lo[63:32] + {xored[23:0], 8'd0};
  end

  // probe walk and result registers
  always_ff @(posedge clk) begin
    if (accept) begin
      kb_hold <= s_tdata[7:0];
      cmd <= s_tuser;
      cmd_last <= s_tlast;
      size_r <= VALUE_WIDTH'(s_tdata[47:8]);
      offset_r <= VALUE_WIDTH'(s_tdata[87:48]);
    end
    unique case (state)
      flpkt_pkg::S_START: begin
        slot <= hash[LOG_SLOTS-1:0] & mask;
        probes <= '0;
        status <= overflow ? flpkt_pkg::ST_TOO_LONG
                : (cmd == flpkt_pkg::CMD_INSERT) ? flpkt_pkg::ST_FULL
                : flpkt_pkg::ST_NOT_FOUND;
        fsz <= '0;
        foff <= '0;
        kidx <= '0;
      end
      flpkt_pkg::S_EVAL: begin
        kidx <= '0;
        if (cmd == flpkt_pkg::CMD_INSERT && !rd_valid) begin
          status <= flpkt_pkg::ST_OK;
        end else if (!(cmd == flpkt_pkg::CMD_LOOKUP && rd_valid
                       && rd_tag == hash[31:0] && rd_len == byte_count)) begin
          slot <= slot_inc;
          probes <= probes + (LOG_SLOTS + 1)'(1);
        end
      end
      flpkt_pkg::S_CMP_EVAL: begin
        if (kv_rdata != ib_rdata) begin
          slot <= slot_inc;
          probes <= probes + (LOG_SLOTS + 1)'(1);
          kidx <= '0;
        end else if (32'(kidx) + 1 == 32'(byte_count)) begin
          status <= flpkt_pkg::ST_OK;
          fsz <= OW'(rd_size);
          foff <= OW'(rd_off);
        end else begin
          kidx <= kidx + KW'(1);
        end
      end
      flpkt_pkg::S_WR_KEY: kidx <= kidx + KW'(1);
      default: ;
    endcase
    if (state == flpkt_pkg::S_OUT && state_next == flpkt_pkg::S_COLLECT) begin
      m_tdata <= {6'd0, foff, fsz, status};
    end
  end

  `FLP_ASSERT(a_no_accept_clearing, !(clearing && s_tready), "item taken during clear")
  `FLP_ASSERT_NEXT(a_out_holds, m_tvalid && !m_tready, m_tvalid, "result dropped")
  `FLP_ASSERT(a_probe_bound, state != flpkt_pkg::S_EVAL || probes < span, "probe walk past table")
endmodule

// File: hdl/flpkt_ram.sv
`timescale 1ns / 1ps
module flpkt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// File: bench/tb_fnv_linear_probe_key_table.sv
`timescale 1ns / 1ps
module tb_fnv_linear_probe_key_table;
  localparam int LOG_SLOTS_DEF = flpkt_pkg::LOG_SLOTS_DEF;
  localparam int NSLOT = 1 << LOG_SLOTS_DEF;
  localparam int KMAX = flpkt_pkg::MAX_KEY_LEN_DEF;
  localparam logic [39:0] VMAX = 40'hFF_FFFF_FFFF;
  localparam logic [63:0] FNV_BASIS = flpkt_pkg::FNV_BASIS;
  localparam logic [63:0] FNV_PRIME = flpkt_pkg::FNV_PRIME;
  localparam logic [3:0] INDEX_BITS_RST = flpkt_pkg::INDEX_BITS_RST;
  localparam logic CMD_INSERT = flpkt_pkg::CMD_INSERT;
  localparam logic CMD_LOOKUP = flpkt_pkg::CMD_LOOKUP;
  localparam flpkt_pkg::status_t ST_OK = flpkt_pkg::ST_OK;
  localparam flpkt_pkg::status_t ST_NOT_FOUND = flpkt_pkg::ST_NOT_FOUND;
  localparam flpkt_pkg::status_t ST_FULL = flpkt_pkg::ST_FULL;
  localparam flpkt_pkg::status_t ST_TOO_LONG = flpkt_pkg::ST_TOO_LONG;

  typedef struct packed {
    flpkt_pkg::status_t st;
    logic [39:0]        fsz;
    logic [39:0]        foff;
  } lookup_res_t;

  typedef struct packed {
    bit          known;
    lookup_res_t res;
  } typed_res_t;

  typedef enum bit {ROW_KEY, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t          kind;
    logic               cmd;
    int                 len;
    logic [7:0]         b0;
    logic [7:0]         step;
    logic [39:0]        sz;
    logic [39:0]        off;
    bit                 known;
    flpkt_pkg::status_t st;
    logic [39:0]        fsz;
    logic [39:0]        foff;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [3:0] cfg_wdata = '0;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [87:0] s_tdata = '0;
  logic s_tlast = 1'b0;
  logic s_tuser = 1'b0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [87:0] m_tdata;

  fnv_linear_probe_key_table DUT (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .s_tlast(s_tlast), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  // clock, period 4 ns
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // shadow table state
  bit          tab_valid [NSLOT];
  logic [7:0]  tab_key [NSLOT][KMAX];
  int          tab_len [NSLOT];
  logic [31:0] tab_tag [NSLOT];
  logic [39:0] tab_size [NSLOT];
  logic [39:0] tab_off [NSLOT];
  logic [7:0]  key_buf [KMAX];
  logic [63:0] key_hash = FNV_BASIS;
  int          key_cnt = 0;
  bit          key_long = 0;
  logic [3:0]  idx_bits = INDEX_BITS_RST;

  lookup_res_t lookup_q [$];
  typed_res_t  typed_q [$];
  int errors = 0;
  int n_items = 0, n_results = 0, n_found = 0, n_full = 0, n_long = 0;
  int tx_idle = 22, rx_idle = 52;

  // probe the shadow table with the completed key
  function automatic lookup_res_t probe_table(logic cmd);
    lookup_res_t r;
    int bits, mask, i;
    bit same;
    r = '{st: ST_NOT_FOUND, fsz: '0, foff: '0};
    bits = (idx_bits == 0) ? 1 : (idx_bits > LOG_SLOTS_DEF) ? LOG_SLOTS_DEF : idx_bits;
    mask = (1 << bits) - 1;
    if (key_long) begin
      r.st = ST_TOO_LONG;
    end else if (cmd == CMD_INSERT) begin
      r.st = ST_FULL;
      for (int s = 0; s <= mask; s++) begin
        i = (int'(key_hash[19:0]) + s) & mask;
        if (!tab_valid[i]) begin
          tab_valid[i] = 1;
          for (int k = 0; k < key_cnt; k++) tab_key[i][k] = key_buf[k];
          tab_len[i] = key_cnt;
          tab_tag[i] = key_hash[31:0];
          tab_size[i] = s_tdata[47:8];
          tab_off[i] = s_tdata[87:48];
          r.st = ST_OK;
          break;
        end
      end
    end else begin
      for (int s = 0; s <= mask; s++) begin
        i = (int'(key_hash[19:0]) + s) & mask;
        if (!tab_valid[i]) break;
        same = (tab_tag[i] == key_hash[31:0]) && (tab_len[i] == key_cnt);
        for (int k = 0; k < key_cnt; k++) if (tab_key[i][k] != key_buf[k]) same = 0;
        if (same) begin
          r = '{st: ST_OK, fsz: tab_size[i], foff: tab_off[i]};
          break;
        end
      end
    end
    key_hash = FNV_BASIS;
    key_cnt = 0;
    key_long = 0;
    return r;
  endfunction

  // follow accepted items and check results
  always @(posedge clk) begin
    lookup_res_t r;
    typed_res_t t;
    if (!rst) begin
      if (cfg_we) idx_bits = cfg_wdata;
      if (s_tvalid && s_tready) begin
        n_items++;
        key_hash = (key_hash ^ {56'd0, s_tdata[7:0]}) * FNV_PRIME;
        if (key_cnt < KMAX) begin
          key_buf[key_cnt] = s_tdata[7:0];
          key_cnt++;
        end else begin
          key_long = 1;
        end
        if (s_tlast) begin
          r = probe_table(s_tuser);
          t = typed_q.pop_front();
          lookup_q.push_back(t.known ? t.res : r);
        end
      end
      if (m_tvalid && m_tready) begin
        n_results++;
        if (lookup_q.size() == 0) begin
          $display("%0t: result exp none got %h", $time, m_tdata);
          errors++;
        end else begin
          r = lookup_q.pop_front();
          if (m_tdata[1:0] == ST_OK) n_found++;
          if (m_tdata[1:0] == ST_FULL) n_full++;
          if (m_tdata[1:0] == ST_TOO_LONG) n_long++;
          if (m_tdata[1:0] !== r.st) begin
            $display("%0t: status exp %0d got %0d", $time, r.st, m_tdata[1:0]);
            errors++;
          end
          if (m_tdata[41:2] !== r.fsz) begin
            $display("%0t: found_size exp %h got %h", $time, r.fsz, m_tdata[41:2]);
            errors++;
          end
          if (m_tdata[81:42] !== r.foff) begin
            $display("%0t: found_offset exp %h got %h", $time, r.foff, m_tdata[81:42]);
            errors++;
          end
        end
      end
    end
  end

  // result side back-pressure
  always @(negedge clk) m_tready <= ($urandom_range(99) >= rx_idle);

  // one byte item, held until accepted
  task automatic send_byte(logic cmd, logic [7:0] b, logic last,
                           logic [39:0] sz, logic [39:0] off);
    while ($urandom_range(99) < tx_idle) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {off, sz, b};
    s_tlast <= last;
    s_tuser <= cmd;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  logic [7:0] cur_key [64];
  int cur_len;

  function automatic logic [39:0] rand40();
    return {8'($urandom_range(255)), $urandom};
  endfunction

  // whole key; only the last byte carries the real command and values
  task automatic send_key(logic cmd, logic [39:0] sz, logic [39:0] off, typed_res_t t);
    for (int k = 0; k < cur_len - 1; k++)
      send_byte($urandom_range(1), cur_key[k], 1'b0, rand40(), rand40());
    typed_q.push_back(t);
    send_byte(cmd, cur_key[cur_len - 1], 1'b1, sz, off);
  endtask

  task automatic drain();
    int guard;
    s_tvalid <= 1'b0;
    guard = 0;
    while (lookup_q.size() != 0 && guard < 400000) begin
      @(negedge clk);
      guard++;
    end
    repeat (40) @(negedge clk);
  endtask

  task automatic write_bits(logic [3:0] v);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  dir_row_t dir_tab [16];
  logic [7:0] pool_key [64][40];
  int pool_len [64];
  int pool_n = 0;

  initial begin
    typed_res_t t;
    int p;
    dir_tab = '{
      // lookups and inserts at the reset index width
      '{ROW_KEY, CMD_LOOKUP, 1, 8'h41, 8'h00, 40'd0, 40'd0, 1, ST_NOT_FOUND, 40'd0, 40'd0},
      '{ROW_KEY, CMD_INSERT, 1, 8'h00, 8'h00, VMAX, 40'd0, 1, ST_OK, 40'd0, 40'd0},
      '{ROW_KEY, CMD_LOOKUP, 1, 8'h00, 8'h00, 40'd7, 40'd9, 1, ST_OK, VMAX, 40'd0},
      '{ROW_KEY, CMD_INSERT, 32, 8'hFF, 8'h00, 40'd0, VMAX, 1, ST_OK, 40'd0, 40'd0},
      '{ROW_KEY, CMD_LOOKUP, 32, 8'hFF, 8'h00, 40'd0, 40'd0, 1, ST_OK, 40'd0, VMAX},
      '{ROW_KEY, CMD_INSERT, 33, 8'h10, 8'h03, 40'd1, 40'd2, 1, ST_TOO_LONG, 40'd0, 40'd0},
      '{ROW_KEY, CMD_LOOKUP, 40, 8'hFF, 8'h00, 40'd0, 40'd0, 1, ST_TOO_LONG, 40'd0, 40'd0},
      '{ROW_KEY, CMD_LOOKUP, 31, 8'hFF, 8'h00, 40'd0, 40'd0, 1, ST_NOT_FOUND, 40'd0, 40'd0},
      // duplicate key, first stored copy answers
      '{ROW_KEY, CMD_INSERT, 1, 8'h00, 8'h00, 40'd5, 40'd6, 1, ST_OK, 40'd0, 40'd0},
      '{ROW_KEY, CMD_LOOKUP, 1, 8'h00, 8'h00, 40'd0, 40'd0, 0, ST_OK, 40'd0, 40'd0},
      // width 0 clamps to one bit: two slots, then full
      '{ROW_CFG, CMD_INSERT, 0, 8'h00, 8'h00, 40'd0, 40'd0, 0, ST_OK, 40'd0, 40'd0},
      '{ROW_KEY, CMD_INSERT, 4, 8'h61, 8'h01, 40'd11, 40'd12, 0, ST_OK, 40'd0, 40'd0},
      '{ROW_KEY, CMD_INSERT, 5, 8'h62, 8'h01, 40'd13, 40'd14, 0, ST_OK, 40'd0, 40'd0},
      '{ROW_KEY, CMD_INSERT, 6, 8'h63, 8'h01, 40'd15, 40'd16, 0, ST_OK, 40'd0, 40'd0},
      '{ROW_KEY, CMD_LOOKUP, 7, 8'h70, 8'h05, 40'd0, 40'd0, 1, ST_NOT_FOUND, 40'd0, 40'd0},
      '{ROW_KEY, CMD_LOOKUP, 4, 8'h61, 8'h01, 40'd0, 40'd0, 0, ST_OK, 40'd0, 40'd0}
    };

    repeat (8) @(negedge clk);
    rst <= 1'b0;

    // directed table
    foreach (dir_tab[r]) begin
      if (dir_tab[r].kind == ROW_CFG) begin
        drain();
        write_bits(4'd0);
      end else begin
        cur_len = dir_tab[r].len;
        for (int k = 0; k < cur_len; k++)
          cur_key[k] = 8'(dir_tab[r].b0 + k * dir_tab[r].step);
        t.known = dir_tab[r].known;
        t.res = '{st: dir_tab[r].st, fsz: dir_tab[r].fsz, foff: dir_tab[r].foff};
        send_key(dir_tab[r].cmd, dir_tab[r].sz, dir_tab[r].off, t);
      end
    end
    drain();

    // random phases: idling mode by pairs, index width varied
    for (int ph = 0; ph < 6; ph++) begin
      case (ph / 2)
        0: begin tx_idle = 22; rx_idle = 52; end
        1: begin tx_idle = 52; rx_idle = 22; end
        default: begin tx_idle = 0; rx_idle = 0; end
      endcase
      case (ph)
        0: write_bits(4'd3);
        1: write_bits(4'd15);
        2: write_bits(4'd2);
        3: write_bits(4'd10);
        4: write_bits(4'd1);
        default: write_bits(4'($urandom_range(4, 9)));
      endcase
      repeat (6) begin
        t.known = 0;
        t.res = '0;
        if (pool_n > 0 && $urandom_range(99) < 45) begin
          // mostly stored keys, sometimes with one byte changed
          p = $urandom_range(pool_n - 1);
          cur_len = pool_len[p];
          for (int k = 0; k < cur_len; k++) cur_key[k] = pool_key[p][k];
          if ($urandom_range(9) == 0) cur_key[$urandom_range(cur_len - 1)] ^= 8'h01;
        end else begin
          case ($urandom_range(19)) inside
            0: cur_len = $urandom_range(33, 36);
            [1:2]: cur_len = $urandom_range(9, 32);
            default: cur_len = $urandom_range(1, 6);
          endcase
          for (int k = 0; k < cur_len; k++) cur_key[k] = 8'($urandom_range(255));
        end
        if ($urandom_range(1)) begin
          send_key(CMD_LOOKUP, rand40(), rand40(), t);
        end else begin
          send_key(CMD_INSERT, rand40(), rand40(), t);
          if (pool_n < 64) begin
            p = pool_n;
            pool_n++;
          end else begin
            p = $urandom_range(63);
          end
          pool_len[p] = cur_len;
          for (int k = 0; k < cur_len; k++) pool_key[p][k] = cur_key[k];
        end
      end
      drain();
    end

    $display("items %0d, results %0d: found/inserted %0d, full %0d, too long %0d",
             n_items, n_results, n_found, n_full, n_long);
    $display("several index widths incl. both clamps, three idling mixes, duplicates");
    if (errors == 0 && lookup_q.size() == 0) begin
      $display("tb_fnv_linear_probe_key_table: PASS");
    end else begin
      $display("tb_fnv_linear_probe_key_table: FAIL");
    end
    $finish;
  end

  // overall time limit
  initial begin
    #20ms;
    $display("tb_fnv_linear_probe_key_table: FAIL");
    $finish;
  end
endmodule
